### hw/rtl/rcjt_pkg.sv
package rcjt_pkg;

	localparam int NUM_JOINTS = 7;
	localparam int POS_W      = 20;
	localparam int DIFF_W     = POS_W + 1;
	localparam int COUNT_W    = 16;
	localparam int LEN_W      = 22;
	localparam int STEP_W     = 16;
	localparam int THR_W      = 21;
	localparam int CFG_W      = 21;
	localparam int ACC_W      = 43;
	localparam int JIDX_W     = $clog2(NUM_JOINTS);
	localparam int IT_W       = 6;

	localparam int SQRT_ITERS = 22;
	localparam int DIV_ITERS  = 32;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic [STEP_W-1:0] STEP_SIZE_RST = 16'd655;
	localparam logic [THR_W-1:0]  MOVE_THR_RST  = 21'd26214;

	localparam logic [1:0] KIND_TICK = 2'd0;
	localparam logic [1:0] KIND_MEAS = 2'd1;
	localparam logic [1:0] KIND_TGT  = 2'd2;

	localparam logic REG_STEP_SIZE = 1'b0;
	localparam logic REG_MOVE_THR  = 1'b1;

	// series coefficients of (1 - cos(pi*x))/2 in x^2, Q30
	localparam logic [31:0] CF1 = 32'd2649351758;
	localparam logic [31:0] CF2 = 32'd2179004479;
	localparam logic [31:0] CF3 = 32'd716863734;
	localparam logic [31:0] CF4 = 32'd126342170;
	localparam logic [31:0] CF5 = 32'd13854969;

	typedef logic signed [POS_W-1:0] pos_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD_MEAS,
		OP_LOAD_TGT,
		OP_LATCH,
		OP_SQ_MUL,
		OP_SQ_ACC,
		OP_SQRT_INIT,
		OP_SQRT_STEP,
		OP_DIV_LEN_INIT,
		OP_DIV_PH_INIT,
		OP_DIV_STEP,
		OP_TOTAL,
		OP_COUNT_INC,
		OP_PHASE,
		OP_Z_MUL,
		OP_Z,
		OP_H_MUL,
		OP_H_SUB,
		OP_W,
		OP_MIX_MUL,
		OP_MIX_ADD,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t            op;
		logic [JIDX_W-1:0] j;
		logic [1:0]        h;
	} dp_cmd_t;

	typedef struct packed {
		logic active;
		logic seg_done;
		logic emit;
		logic out_busy;
	} dp_stat_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SQ_MUL,
		ST_SQ_ACC,
		ST_SQRT_INIT,
		ST_SQRT,
		ST_DIV_LEN,
		ST_DIV,
		ST_TOTAL,
		ST_INC,
		ST_DIV_PH,
		ST_PHASE,
		ST_Z_MUL,
		ST_Z,
		ST_H_MUL,
		ST_H_SUB,
		ST_W_MUL,
		ST_W,
		ST_MIX_MUL,
		ST_MIX_ADD,
		ST_OUT
	} ctl_state_t;

	function automatic logic [31:0] horner_coef(input logic [1:0] h);
		logic [31:0] c;
		case (h)
			2'd0:    c = CF4;
			2'd1:    c = CF3;
			2'd2:    c = CF2;
			default: c = CF1;
		endcase
		return c;
	endfunction

endpackage

### hw/rtl/rcjt_in_if.sv
interface rcjt_in_if;
	logic              valid;
	logic              ready;
	logic [1:0]        kind;
	logic signed [19:0] pos_joint_0;
	logic signed [19:0] pos_joint_1;
	logic signed [19:0] pos_joint_2;
	logic signed [19:0] pos_joint_3;
	logic signed [19:0] pos_joint_4;
	logic signed [19:0] pos_joint_5;
	logic signed [19:0] pos_joint_6;

	modport source (output valid, kind, pos_joint_0, pos_joint_1, pos_joint_2, pos_joint_3,
		pos_joint_4, pos_joint_5, pos_joint_6, input ready);
	modport sink (input valid, kind, pos_joint_0, pos_joint_1, pos_joint_2, pos_joint_3,
		pos_joint_4, pos_joint_5, pos_joint_6, output ready);
endinterface

### hw/rtl/rcjt_out_if.sv
interface rcjt_out_if;
	logic              valid;
	logic              ready;
	logic signed [19:0] cmd_joint_0;
	logic signed [19:0] cmd_joint_1;
	logic signed [19:0] cmd_joint_2;
	logic signed [19:0] cmd_joint_3;
	logic signed [19:0] cmd_joint_4;
	logic signed [19:0] cmd_joint_5;
	logic signed [19:0] cmd_joint_6;

	modport source (output valid, cmd_joint_0, cmd_joint_1, cmd_joint_2, cmd_joint_3,
		cmd_joint_4, cmd_joint_5, cmd_joint_6, input ready);
	modport sink (input valid, cmd_joint_0, cmd_joint_1, cmd_joint_2, cmd_joint_3,
		cmd_joint_4, cmd_joint_5, cmd_joint_6, output ready);
endinterface

### hw/rtl/rcjt_ctrl.sv
module rcjt_ctrl import rcjt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_kind,
	output logic       in_ready,
	input  dp_stat_t   stat,
	output dp_cmd_t    cmd
);

	ctl_state_t        st_q, st_d;
	logic [JIDX_W-1:0] j_q, j_d;
	logic [1:0]        h_q, h_d;
	logic [IT_W-1:0]   it_q, it_d;
	logic              ph_q, ph_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			j_q  <= '0;
			h_q  <= '0;
			it_q <= '0;
			ph_q <= 1'b0;
		end else begin
			st_q <= st_d;
			j_q  <= j_d;
			h_q  <= h_d;
			it_q <= it_d;
			ph_q <= ph_d;
		end
	end

	always_comb begin
		st_d = st_q;
		j_d  = j_q;
		h_d  = h_q;
		it_d = it_q;
		ph_d = ph_q;
		case (st_q)
			ST_IDLE: begin
				if (in_valid && in_kind == KIND_TICK && stat.active) begin
					if (stat.seg_done) begin
						st_d = ST_SQ_MUL;
						j_d  = '0;
					end else begin
						st_d = ST_INC;
					end
				end
			end
			ST_SQ_MUL: st_d = ST_SQ_ACC;
			ST_SQ_ACC: begin
				if (j_q == JIDX_W'(NUM_JOINTS - 1)) begin
					st_d = ST_SQRT_INIT;
				end else begin
					j_d  = j_q + 1'b1;
					st_d = ST_SQ_MUL;
				end
			end
			ST_SQRT_INIT: begin
				st_d = ST_SQRT;
				it_d = '0;
			end
			ST_SQRT: begin
				it_d = it_q + 1'b1;
				if (it_q == IT_W'(SQRT_ITERS - 1))
					st_d = ST_DIV_LEN;
			end
			ST_DIV_LEN: begin
				st_d = ST_DIV;
				it_d = '0;
				ph_d = 1'b0;
			end
			ST_DIV: begin
				it_d = it_q + 1'b1;
				if (it_q == IT_W'(DIV_ITERS - 1))
					st_d = ph_q ? ST_PHASE : ST_TOTAL;
			end
			ST_TOTAL: st_d = ST_INC;
			ST_INC:   st_d = stat.emit ? ST_DIV_PH : ST_IDLE;
			ST_DIV_PH: begin
				st_d = ST_DIV;
				it_d = '0;
				ph_d = 1'b1;
			end
			ST_PHASE: st_d = ST_Z_MUL;
			ST_Z_MUL: st_d = ST_Z;
			ST_Z: begin
				st_d = ST_H_MUL;
				h_d  = '0;
			end
			ST_H_MUL: st_d = ST_H_SUB;
			ST_H_SUB: begin
				if (h_q == 2'd3) begin
					st_d = ST_W_MUL;
				end else begin
					h_d  = h_q + 1'b1;
					st_d = ST_H_MUL;
				end
			end
			ST_W_MUL: st_d = ST_W;
			ST_W: begin
				st_d = ST_MIX_MUL;
				j_d  = '0;
			end
			ST_MIX_MUL: st_d = ST_MIX_ADD;
			ST_MIX_ADD: begin
				if (j_q == JIDX_W'(NUM_JOINTS - 1)) begin
					st_d = ST_OUT;
				end else begin
					j_d  = j_q + 1'b1;
					st_d = ST_MIX_MUL;
				end
			end
			ST_OUT: begin
				if (!stat.out_busy)
					st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (st_q == ST_IDLE);
		cmd.op   = OP_NONE;
		cmd.j    = j_q;
		cmd.h    = h_q;
		case (st_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_kind == KIND_MEAS)
						cmd.op = OP_LOAD_MEAS;
					else if (in_kind == KIND_TGT)
						cmd.op = OP_LOAD_TGT;
					else if (in_kind == KIND_TICK && stat.active && stat.seg_done)
						cmd.op = OP_LATCH;
				end
			end
			ST_SQ_MUL:    cmd.op = OP_SQ_MUL;
			ST_SQ_ACC:    cmd.op = OP_SQ_ACC;
			ST_SQRT_INIT: cmd.op = OP_SQRT_INIT;
			ST_SQRT:      cmd.op = OP_SQRT_STEP;
			ST_DIV_LEN:   cmd.op = OP_DIV_LEN_INIT;
			ST_DIV:       cmd.op = OP_DIV_STEP;
			ST_TOTAL:     cmd.op = OP_TOTAL;
			ST_INC:       cmd.op = OP_COUNT_INC;
			ST_DIV_PH:    cmd.op = OP_DIV_PH_INIT;
			ST_PHASE:     cmd.op = OP_PHASE;
			ST_Z_MUL:     cmd.op = OP_Z_MUL;
			ST_Z:         cmd.op = OP_Z;
			ST_H_MUL:     cmd.op = OP_H_MUL;
			ST_H_SUB:     cmd.op = OP_H_SUB;
			ST_W_MUL:     cmd.op = OP_H_MUL;
			ST_W:         cmd.op = OP_W;
			ST_MIX_MUL:   cmd.op = OP_MIX_MUL;
			ST_MIX_ADD:   cmd.op = OP_MIX_ADD;
			ST_OUT:       cmd.op = stat.out_busy ? OP_NONE : OP_OUT;
			default:      cmd.op = OP_NONE;
		endcase
	end

endmodule

### hw/rtl/rcjt_datapath.sv
module rcjt_datapath import rcjt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	output dp_stat_t         stat,
	input  pos_t             pos_in [NUM_JOINTS],
	input  logic             cfg_we,
	input  logic             cfg_idx,
	input  logic [CFG_W-1:0] cfg_data,
	output logic             res_valid,
	input  logic             res_ready,
	output pos_t             res_pos [NUM_JOINTS]
);

	pos_t meas_q  [NUM_JOINTS];
	pos_t tgt_q   [NUM_JOINTS];
	pos_t start_q [NUM_JOINTS];
	pos_t goal_q  [NUM_JOINTS];
	pos_t mix_q   [NUM_JOINTS];
	pos_t out_q   [NUM_JOINTS];

	logic [COUNT_W-1:0] count_q, total_q;
	logic [LEN_W-1:0]   len_q;
	logic               active_q, out_valid_q;
	logic [STEP_W-1:0]  step_q;
	logic [THR_W-1:0]   thr_q;

	logic [ACC_W-1:0]   acc_q;
	logic [ACC_W:0]     sq_n_q;
	logic [23:0]        sq_rem_q;
	logic [LEN_W-1:0]   sq_root_q;
	logic [15:0]        dv_rem_q;
	logic [31:0]        dv_quo_q;
	logic [15:0]        dv_div_q;
	logic [15:0]        x_q;
	logic               flip_q;
	logic [28:0]        z_q;
	logic [31:0]        t_q;
	logic [16:0]        w_q;
	logic signed [62:0] prod_q;

	logic signed [DIFF_W-1:0] diff;
	logic signed [29:0]       ma;
	logic signed [32:0]       mb;
	logic [25:0]              rem_sh, trial;
	logic [16:0]              dv_sh;
	logic [17:0]              p_clip;
	logic [16:0]              p_half;
	logic [32:0]              w_rnd;
	logic [16:0]              w_raw;
	logic signed [62:0]       mix_tmp;

	assign diff = {goal_q[cmd.j][POS_W-1], goal_q[cmd.j]}
		- {start_q[cmd.j][POS_W-1], start_q[cmd.j]};

	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			OP_SQ_MUL: begin
				ma = {{(30-DIFF_W){diff[DIFF_W-1]}}, diff};
				mb = {{(33-DIFF_W){diff[DIFF_W-1]}}, diff};
			end
			OP_Z_MUL: begin
				ma = {14'b0, x_q};
				mb = {17'b0, x_q};
			end
			OP_H_MUL: begin
				ma = {1'b0, z_q};
				mb = {1'b0, t_q};
			end
			OP_MIX_MUL: begin
				ma = {13'b0, w_q};
				mb = {{(33-DIFF_W){diff[DIFF_W-1]}}, diff};
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	// restoring root: two radicand bits in, one root bit out
	assign rem_sh = {sq_rem_q, sq_n_q[ACC_W:ACC_W-1]};
	assign trial  = {2'b0, sq_root_q, 2'b01};
	// restoring divide: one quotient bit per step
	assign dv_sh  = {dv_rem_q, dv_quo_q[31]};

	// clip phase to a full turn and fold it into a half turn
	always_comb begin
		p_clip = (dv_quo_q > 32'd131072) ? 18'd131072 : dv_quo_q[17:0];
		p_half = (p_clip > 18'd65536) ? 17'(18'd131072 - p_clip) : p_clip[16:0];
	end

	assign w_rnd   = {1'b0, prod_q[61:30]} + 33'd8192;
	assign w_raw   = (w_rnd[32:14] > 19'd65536) ? 17'd65536 : w_rnd[30:14];
	assign mix_tmp = prod_q + 63'sd32768;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			total_q     <= '0;
			len_q       <= '0;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
			step_q      <= STEP_SIZE_RST;
			thr_q       <= MOVE_THR_RST;
			for (int i = 0; i < NUM_JOINTS; i++) begin
				meas_q[i]  <= '0;
				tgt_q[i]   <= '0;
				start_q[i] <= '0;
				goal_q[i]  <= '0;
			end
		end else begin
			if (cfg_we) begin
				if (cfg_idx == REG_STEP_SIZE)
					step_q <= cfg_data[STEP_W-1:0];
				else
					thr_q <= cfg_data[THR_W-1:0];
			end
			if (out_valid_q && res_ready)
				out_valid_q <= 1'b0;
			case (cmd.op)
				OP_LOAD_MEAS: meas_q <= pos_in;
				OP_LOAD_TGT: begin
					tgt_q    <= pos_in;
					active_q <= 1'b1;
				end
				OP_LATCH: begin
					start_q <= meas_q;
					goal_q  <= tgt_q;
					count_q <= '0;
				end
				OP_DIV_LEN_INIT: len_q <= sq_root_q;
				OP_TOTAL: begin
					if (dv_quo_q >= {16'b0, COUNT_MAX})
						total_q <= COUNT_MAX;
					else
						total_q <= dv_quo_q[COUNT_W-1:0] + 1'b1;
				end
				OP_COUNT_INC: count_q <= count_q + 1'b1;
				OP_OUT:       out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
		case (cmd.op)
			OP_LATCH:  acc_q <= '0;
			OP_SQ_ACC: acc_q <= acc_q + prod_q[ACC_W-1:0];
			OP_SQRT_INIT: begin
				sq_n_q    <= {1'b0, acc_q};
				sq_rem_q  <= '0;
				sq_root_q <= '0;
			end
			OP_SQRT_STEP: begin
				sq_n_q <= {sq_n_q[ACC_W-2:0], 2'b00};
				if (rem_sh >= trial) begin
					sq_rem_q  <= 24'(rem_sh - trial);
					sq_root_q <= {sq_root_q[LEN_W-2:0], 1'b1};
				end else begin
					sq_rem_q  <= rem_sh[23:0];
					sq_root_q <= {sq_root_q[LEN_W-2:0], 1'b0};
				end
			end
			OP_DIV_LEN_INIT: begin
				dv_rem_q <= '0;
				dv_quo_q <= {10'b0, sq_root_q};
				dv_div_q <= (step_q == '0) ? 16'd1 : step_q;
			end
			OP_DIV_PH_INIT: begin
				dv_rem_q <= '0;
				dv_quo_q <= {count_q, 16'b0};
				dv_div_q <= total_q - 1'b1;
			end
			OP_DIV_STEP: begin
				if (dv_sh >= {1'b0, dv_div_q}) begin
					dv_rem_q <= 16'(dv_sh - {1'b0, dv_div_q});
					dv_quo_q <= {dv_quo_q[30:0], 1'b1};
				end else begin
					dv_rem_q <= dv_sh[15:0];
					dv_quo_q <= {dv_quo_q[30:0], 1'b0};
				end
			end
			OP_PHASE: begin
				if (p_half > 17'd32768) begin
					x_q    <= 16'(17'd65536 - p_half);
					flip_q <= 1'b1;
				end else begin
					x_q    <= p_half[15:0];
					flip_q <= 1'b0;
				end
			end
			OP_Z: begin
				z_q <= prod_q[30:2];
				t_q <= CF5;
			end
			OP_H_SUB: t_q <= horner_coef(cmd.h) - prod_q[61:30];
			OP_W:     w_q <= flip_q ? 17'(17'd65536 - w_raw) : w_raw;
			OP_MIX_ADD: mix_q[cmd.j] <= start_q[cmd.j] + mix_tmp[35:16];
			OP_OUT:   out_q <= mix_q;
			default: ;
		endcase
	end

	assign stat.active   = active_q;
	assign stat.seg_done = (count_q >= total_q);
	assign stat.emit     = (total_q > 16'd1) && (len_q >= {1'b0, thr_q});
	assign stat.out_busy = out_valid_q;

	assign res_valid = out_valid_q;
	assign res_pos   = out_q;

endmodule

### hw/rtl/raised_cosine_joint_trajectory_top.sv
// channel  | role   | beat carries
// ---------+--------+------------------------------------------------
// item     | sink   | kind, pos_joint_0..6 (Q4.16 rad)
// result   | source | cmd_joint_0..6 (Q4.16 rad)
// cfg      | write  | cfg_idx 0 step_size, 1 move_threshold
//
// Position beats, and ticks while the block is unarmed, leave it in ST_IDLE.
// A tick inside a segment runs ST_INC, and when it emits also the phase division and mix.
// A tick that opens a segment first takes the length: the bit-serial root and the
// shared restoring divider (length over step size) do that work.
// Result sits in an output register; a new item is taken while it waits.
// An emitting tick stalls in its last cycle while the previous result is unread.
// arst_n clears control, counters and latches; no clearing pass.
module raised_cosine_joint_trajectory_top import rcjt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	rcjt_in_if.sink          item,
	rcjt_out_if.source       result,
	input  logic             cfg_we,
	input  logic             cfg_idx,
	input  logic [CFG_W-1:0] cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	pos_t     pos_in  [NUM_JOINTS];
	pos_t     res_pos [NUM_JOINTS];

	assign pos_in[0] = item.pos_joint_0;
	assign pos_in[1] = item.pos_joint_1;
	assign pos_in[2] = item.pos_joint_2;
	assign pos_in[3] = item.pos_joint_3;
	assign pos_in[4] = item.pos_joint_4;
	assign pos_in[5] = item.pos_joint_5;
	assign pos_in[6] = item.pos_joint_6;

	assign result.cmd_joint_0 = res_pos[0];
	assign result.cmd_joint_1 = res_pos[1];
	assign result.cmd_joint_2 = res_pos[2];
	assign result.cmd_joint_3 = res_pos[3];
	assign result.cmd_joint_4 = res_pos[4];
	assign result.cmd_joint_5 = res_pos[5];
	assign result.cmd_joint_6 = res_pos[6];

	rcjt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_kind  (item.kind),
		.in_ready (item.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rcjt_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.pos_in    (pos_in),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.res_valid (result.valid),
		.res_ready (result.ready),
		.res_pos   (res_pos)
	);

endmodule

### hw/rtl/rcjt_checker.sv
module rcjt_checker import rcjt_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic [1:0]  item_kind,
	input logic        result_valid,
	input logic        result_ready,
	input logic [19:0] result_joint_0
);

	// a result beat comes only from a busy block
	a_rise_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(!item_ready))
		else $error("result raised while input side was open");

	// after a position beat the input side is ready again in the next cycle
	a_load_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready && item_kind != KIND_TICK) |=> item_ready)
		else $error("position beat held the input side");

	// no fresh result while idle
	a_idle_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(item_ready && !item_valid && !result_valid) |=> !result_valid)
		else $error("result appeared from idle");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=> (result_valid && $stable(result_joint_0)))
		else $error("stalled result changed");

endmodule

bind raised_cosine_joint_trajectory_top rcjt_checker u_rcjt_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_valid     (item.valid),
	.item_ready     (item.ready),
	.item_kind      (item.kind),
	.result_valid   (result.valid),
	.result_ready   (result.ready),
	.result_joint_0 (result.cmd_joint_0)
);
